/* src/pbr_pkg.sv */
// pbr_pkg: shared types and constants of the polynomial bisection root finder
// no dependencies; imported by pbr_ctrl, pbr_datapath and polynomial_bisection_root

package pbr_pkg;

    localparam int MAX_DEGREE_DEF = 10;
    localparam int FRAC_BITS_DEF  = 32;

    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DEG_W      = 4;
    localparam int TOL_W      = 32;
    localparam int TOL_FRAC   = 32;
    localparam int STEP_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [TOL_W-1:0]  TOL_RESET   = 32'd4295;
    localparam logic [STEP_W-1:0] LIMIT_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

    localparam logic [1:0] PART_LO_LO = 2'd0;
    localparam logic [1:0] PART_HI_LO = 2'd1;
    localparam logic [1:0] PART_LO_HI = 2'd2;
    localparam logic [1:0] PART_HI_HI = 2'd3;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SOLVE = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_TOL      = 3'd0,
        RES_MID_ZERO = 3'd1,
        RES_ENDPOINT = 3'd2,
        RES_NO_SIGN  = 3'd3,
        RES_LIMIT    = 3'd4
    } res_code_t;

    typedef enum logic [1:0] {
        ROOT_MID,
        ROOT_LOWER,
        ROOT_UPPER,
        ROOT_ZERO
    } root_sel_t;

    typedef enum logic [1:0] {
        X_LOWER,
        X_UPPER,
        X_MID
    } x_sel_t;

    typedef struct packed {
        logic      coef_write;
        logic      solve_load;
        logic      ev_start;
        x_sel_t    x_sel;
        logic      mul_load;
        logic      tol_load;
        logic      mul_issue;
        logic [1:0] mul_part;
        logic      mul_acc;
        logic      sat;
        logic      add;
        logic      save_lowval;
        logic      bis_mid;
        logic      bis_update;
        logic      res_write;
        res_code_t res_code;
        root_sel_t root_sel;
    } pbr_cmd_t;

    typedef struct packed {
        logic idx_zero;
        logic lowval_zero;
        logic acc_zero;
        logic acc_opposite;
        logic width_met;
        logic step_last;
    } pbr_stat_t;

endpackage

/* src/pbr_datapath.sv */
// pbr_datapath: coefficient store, horner accumulator, shared 32x32 multiplier,
// bisection bounds and step counter; driven by pbr_ctrl, uses pbr_pkg

module pbr_datapath
    import pbr_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  pbr_cmd_t                cmd,
    output pbr_stat_t               stat,
    input  logic [DEG_W-1:0]        coef_index,
    input  logic [DATA_W-1:0]       coef_value,
    input  logic [DATA_W-1:0]       left_end,
    input  logic [DATA_W-1:0]       right_end,
    input  logic [DEG_W-1:0]        degree,
    input  logic [TOL_W-1:0]        tolerance,
    input  logic [STEP_W-1:0]       iteration_limit,
    output logic [DATA_W-1:0]       root_value,
    output logic [STEP_W-1:0]       step_count
);

    localparam int IDX_W = $clog2(MAX_DEGREE + 1);
    localparam int CMP_W = (IDX_W > DEG_W) ? IDX_W : DEG_W;

    logic [DATA_W-1:0] coef_mem [0:MAX_DEGREE];

    logic [DATA_W-1:0] lower_reg;
    logic [DATA_W-1:0] upper_reg;
    logic [DATA_W-1:0] lowval_reg;
    logic [DATA_W-1:0] mid_reg;
    logic [DATA_W-1:0] diff_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] mag_a_reg;
    logic [DATA_W-1:0] mag_b_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] pp_reg;
    logic [1:0]        pp_part_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0] psat_reg;
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [CMP_W-1:0]  degree_ext;
    logic [CMP_W-1:0]  index_ext;
    logic [CMP_W-1:0]  max_ext;
    logic [IDX_W-1:0]  deg_eff;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] coef_rd;
    logic [DATA_W-1:0] x_src;
    logic [DATA_W-1:0] acc_mag;
    logic [DATA_W-1:0] x_mag;
    logic [DATA_W-1:0] upper_mag;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [PROD_W-1:0] pp_ext;
    logic [DATA_W-1:0] q_lo;
    logic              q_hi_nz;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] q_sat;
    logic [DATA_W-1:0] psat_d;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] acc_d;
    logic [DATA_W-1:0] mid_d;
    logic [DATA_W-1:0] diff_d;
    logic [PROD_W-1:0] width_lhs;
    logic [STEP_W-1:0] limit_eff;
    logic [STEP_W:0]   step_inc;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

    assign degree_ext = CMP_W'(degree);
    assign index_ext  = CMP_W'(coef_index);
    assign max_ext    = CMP_W'(MAX_DEGREE);
    assign deg_eff    = (degree_ext > max_ext) ? max_ext[IDX_W-1:0] : degree_ext[IDX_W-1:0];
    assign rd_addr    = cmd.ev_start ? deg_eff : (idx_reg - IDX_W'(1));
    assign coef_rd    = coef_mem[rd_addr];

    always_comb
    begin
        unique case (cmd.x_sel)
            X_LOWER: x_src = lower_reg;
            X_UPPER: x_src = upper_reg;
            default: x_src = mid_reg;
        endcase
    end

    assign acc_mag   = mag(acc_reg);
    assign x_mag     = mag(x_reg);
    assign upper_mag = mag(upper_reg);

    // partial product operands
    assign op_a = cmd.mul_part[0] ? mag_a_reg[DATA_W-1:HALF_W] : mag_a_reg[HALF_W-1:0];
    assign op_b = cmd.mul_part[1] ? mag_b_reg[DATA_W-1:HALF_W] : mag_b_reg[HALF_W-1:0];

    always_comb
    begin
        case (pp_part_reg) inside
            PART_LO_LO:             pp_ext = {{DATA_W{1'b0}}, pp_reg};
            PART_HI_LO, PART_LO_HI: pp_ext = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default:                pp_ext = {pp_reg, {DATA_W{1'b0}}};
        endcase
    end

    // scale, saturate and sign the magnitude product
    assign q_lo    = prod_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign q_hi_nz = |prod_reg[PROD_W-1:FRAC_BITS+DATA_W];
    assign lim     = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    assign q_sat   = (q_hi_nz || (q_lo > lim)) ? lim : q_lo;
    assign psat_d  = neg_reg ? (DATA_W'(0) - q_sat) : q_sat;

    // saturating add of the next coefficient
    assign sum   = {psat_reg[DATA_W-1], psat_reg} + {coef_rd[DATA_W-1], coef_rd};
    assign acc_d = (sum[DATA_W] != sum[DATA_W-1])
                 ? (sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}})
                 : sum[DATA_W-1:0];

    // floor midpoint and interval width
    assign mid_d  = {lower_reg[DATA_W-1], lower_reg[DATA_W-1:1]}
                  + {upper_reg[DATA_W-1], upper_reg[DATA_W-1:1]}
                  + DATA_W'(lower_reg[0] & upper_reg[0]);
    assign diff_d = ($signed(upper_reg) >= $signed(lower_reg)) ? (upper_reg - lower_reg)
                                                               : (lower_reg - upper_reg);

    assign width_lhs = {{(PROD_W-DATA_W-TOL_FRAC){1'b0}}, diff_reg, {TOL_FRAC{1'b0}}};

    assign limit_eff = (iteration_limit == '0) ? STEP_W'(1) : iteration_limit;
    assign step_inc  = (STEP_W+1)'(step_reg) + (STEP_W+1)'(1);

    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.lowval_zero  = (lowval_reg == '0);
    assign stat.acc_zero     = (acc_reg == '0);
    assign stat.acc_opposite = (acc_reg[DATA_W-1] != lowval_reg[DATA_W-1]);
    assign stat.width_met    = (width_lhs < prod_reg);
    assign stat.step_last    = (step_inc >= (STEP_W+1)'(limit_eff));

    always_comb
    begin
        unique case (cmd.root_sel)
            ROOT_MID:   root_value = mid_reg;
            ROOT_LOWER: root_value = lower_reg;
            ROOT_UPPER: root_value = upper_reg;
            default:    root_value = '0;
        endcase
    end

    assign step_count = step_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.coef_write && (index_ext <= max_ext))
        begin
            coef_mem[index_ext[IDX_W-1:0]] <= coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.solve_load)
        begin
            lower_reg <= left_end;
            upper_reg <= right_end;
            step_reg  <= '0;
        end
        if (cmd.ev_start)
        begin
            x_reg   <= x_src;
            acc_reg <= coef_rd;
            idx_reg <= deg_eff;
        end
        if (cmd.mul_load)
        begin
            mag_a_reg <= acc_mag;
            mag_b_reg <= x_mag;
            neg_reg   <= acc_reg[DATA_W-1] ^ x_reg[DATA_W-1];
            prod_reg  <= '0;
        end
        if (cmd.tol_load)
        begin
            mag_a_reg <= upper_mag;
            mag_b_reg <= DATA_W'(tolerance);
            neg_reg   <= 1'b0;
            prod_reg  <= '0;
        end
        if (cmd.mul_issue)
        begin
            pp_reg      <= DATA_W'(op_a) * DATA_W'(op_b);
            pp_part_reg <= cmd.mul_part;
        end
        if (cmd.mul_acc)
        begin
            prod_reg <= prod_reg + pp_ext;
        end
        if (cmd.sat)
        begin
            psat_reg <= psat_d;
        end
        if (cmd.add)
        begin
            acc_reg <= acc_d;
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.save_lowval)
        begin
            lowval_reg <= acc_reg;
        end
        if (cmd.bis_mid)
        begin
            mid_reg  <= mid_d;
            diff_reg <= diff_d;
        end
        if (cmd.bis_update)
        begin
            if (acc_reg[DATA_W-1] != lowval_reg[DATA_W-1])
            begin
                upper_reg <= mid_reg;
            end
            else
            begin
                lower_reg  <= mid_reg;
                lowval_reg <= acc_reg;
            end
            step_reg <= step_inc[STEP_W-1:0];
        end
    end

endmodule

/* src/pbr_ctrl.sv */
// pbr_ctrl: sequencer for coefficient loads, horner evaluation and bisection
// steps; issues commands to pbr_datapath, uses pbr_pkg

module pbr_ctrl
    import pbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_accept,
    input  logic      command,
    input  logic      out_free,
    input  pbr_stat_t stat,
    output pbr_cmd_t  cmd,
    output logic      idle
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_START,
        S_EV_LOOP,
        S_MUL,
        S_SAT,
        S_ADD,
        S_CHECK_ENDS,
        S_BIS_MID,
        S_TOL_LOAD,
        S_TOL_CHK,
        S_CHECK_MID,
        S_RESULT
    } state_t;

    localparam logic [2:0] MUL_LAST = 3'd4;

    state_t    state_reg,    state_next;
    logic [2:0] phase_reg,   phase_next;
    x_sel_t    target_reg,   target_next;
    logic      tol_mode_reg, tol_mode_next;
    res_code_t res_code_reg, res_code_next;
    root_sel_t root_sel_reg, root_sel_next;

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        target_next   = target_reg;
        tol_mode_next = tol_mode_reg;
        res_code_next = res_code_reg;
        root_sel_next = root_sel_reg;
        cmd           = '0;
        cmd.x_sel     = target_reg;
        cmd.res_code  = res_code_reg;
        cmd.root_sel  = root_sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == CMD_SOLVE)
                    begin
                        cmd.solve_load = 1'b1;
                        target_next    = X_LOWER;
                        state_next     = S_EV_START;
                    end
                    else
                    begin
                        cmd.coef_write = 1'b1;
                    end
                end
            end
            S_EV_START:
            begin
                cmd.ev_start = 1'b1;
                state_next   = S_EV_LOOP;
            end
            S_EV_LOOP:
            begin
                if (stat.idx_zero)
                begin
                    unique case (target_reg)
                        X_LOWER:
                        begin
                            cmd.save_lowval = 1'b1;
                            target_next     = X_UPPER;
                            state_next      = S_EV_START;
                        end
                        X_UPPER: state_next = S_CHECK_ENDS;
                        default: state_next = S_CHECK_MID;
                    endcase
                end
                else
                begin
                    cmd.mul_load  = 1'b1;
                    tol_mode_next = 1'b0;
                    phase_next    = '0;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_issue = (phase_reg != MUL_LAST);
                cmd.mul_part  = phase_reg[1:0];
                cmd.mul_acc   = (phase_reg != '0);
                if (phase_reg == MUL_LAST)
                begin
                    state_next = tol_mode_reg ? S_TOL_CHK : S_SAT;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_EV_LOOP;
            end
            S_CHECK_ENDS:
            begin
                if (stat.lowval_zero)
                begin
                    res_code_next = RES_ENDPOINT;
                    root_sel_next = ROOT_LOWER;
                    state_next    = S_RESULT;
                end
                else if (stat.acc_zero)
                begin
                    res_code_next = RES_ENDPOINT;
                    root_sel_next = ROOT_UPPER;
                    state_next    = S_RESULT;
                end
                else if (!stat.acc_opposite)
                begin
                    res_code_next = RES_NO_SIGN;
                    root_sel_next = ROOT_ZERO;
                    state_next    = S_RESULT;
                end
                else
                begin
                    state_next = S_BIS_MID;
                end
            end
            S_BIS_MID:
            begin
                cmd.bis_mid = 1'b1;
                state_next  = S_TOL_LOAD;
            end
            S_TOL_LOAD:
            begin
                cmd.tol_load  = 1'b1;
                tol_mode_next = 1'b1;
                phase_next    = '0;
                state_next    = S_MUL;
            end
            S_TOL_CHK:
            begin
                if (stat.width_met)
                begin
                    res_code_next = RES_TOL;
                    root_sel_next = ROOT_MID;
                    state_next    = S_RESULT;
                end
                else
                begin
                    target_next = X_MID;
                    state_next  = S_EV_START;
                end
            end
            S_CHECK_MID:
            begin
                if (stat.acc_zero)
                begin
                    res_code_next = RES_MID_ZERO;
                    root_sel_next = ROOT_MID;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.bis_update = 1'b1;
                    if (stat.step_last)
                    begin
                        res_code_next = RES_LIMIT;
                        root_sel_next = ROOT_MID;
                        state_next    = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_BIS_MID;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.res_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= '0;
            target_reg   <= X_LOWER;
            tol_mode_reg <= 1'b0;
            res_code_reg <= RES_TOL;
            root_sel_reg <= ROOT_MID;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            target_reg   <= target_next;
            tol_mode_reg <= tol_mode_next;
            res_code_reg <= res_code_next;
            root_sel_reg <= root_sel_next;
        end
    end

endmodule

/* src/polynomial_bisection_root.sv */
// polynomial_bisection_root: top level with configuration registers, input
// handshake and output register; instantiates pbr_ctrl and pbr_datapath, uses pbr_pkg
//
// A load item (command 0) writes coef_value to coefficient coef_index and gives
// no result; the block stays idle after it. A solve item (command 1) brackets a root
// of the loaded polynomial between left_end and right_end and gives one result
// item: status, root and iterations.
// in_stall is high while a solve item is at work; load and solve items are
// taken only in the idle state. One Q32.32 product runs on a single 32x32
// multiplier over four partial products; one Horner term runs through the loop,
// multiply, saturate and add states. With d the configured degree, one evaluation
// runs d Horner terms; a solve item evaluates both ends before the first bisection
// step, and each step forms the midpoint, checks the width and evaluates there.
// The result sits in an output register: out_stall holds it there and the
// block may take the next item meanwhile; a further solve result waits in
// the sequencer until the register is free.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// while the block is idle; the user is bound to this, the block does not enforce it.
// Reset clears the sequencer and the output valid flag and sets degree 0, tolerance
// 4295 and iteration limit 1000; coefficients hold no value until loaded.

module polynomial_bisection_root
    import pbr_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [DEG_W-1:0]      coef_index,
    input  logic [DATA_W-1:0]     coef_value,
    input  logic [DATA_W-1:0]     left_end,
    input  logic [DATA_W-1:0]     right_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [DATA_W-1:0]     root,
    output logic [STEP_W-1:0]     iterations,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DEG_W-1:0]    degree_reg;
    logic [TOL_W-1:0]    tolerance_reg;
    logic [STEP_W-1:0]   limit_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   root_reg;
    logic [STEP_W-1:0]   iter_reg;

    logic                idle;
    logic                in_accept;
    logic                out_free;
    pbr_cmd_t            cmd;
    pbr_stat_t           stat;
    logic [DATA_W-1:0]   root_value;
    logic [STEP_W-1:0]   step_count;

    assign in_stall  = !idle;
    assign in_accept = in_valid && idle;
    assign out_free  = !out_valid_reg || !out_stall;

    pbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .command   (command),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle)
    );

    pbr_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .cmd             (cmd),
        .stat            (stat),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .left_end        (left_end),
        .right_end       (right_end),
        .degree          (degree_reg),
        .tolerance       (tolerance_reg),
        .iteration_limit (limit_reg),
        .root_value      (root_value),
        .step_count      (step_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg    <= '0;
            tolerance_reg <= TOL_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEGREE:     degree_reg    <= cfg_data[DEG_W-1:0];
                REG_TOLERANCE:  tolerance_reg <= cfg_data[TOL_W-1:0];
                REG_ITER_LIMIT: limit_reg     <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            status_reg <= cmd.res_code;
            root_reg   <= root_value;
            iter_reg   <= step_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign root       = root_reg;
    assign iterations = iter_reg;

    a_write_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_write |-> out_free)
        else $error("result written while output register is occupied");

    a_solve_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (command == CMD_SOLVE) |=> !cmd.res_write && in_stall)
        else $error("solve item finished without any evaluation");

    a_no_steps_early_exit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_write && ((cmd.res_code == RES_ENDPOINT) || (cmd.res_code == RES_NO_SIGN))
        |-> (step_count == '0))
        else $error("bisection steps counted before the interval was checked");

    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_write && (cmd.res_code == RES_LIMIT)
        |-> (step_count == ((limit_reg == '0) ? STEP_W'(1) : limit_reg)))
        else $error("limit reported with a step count other than the limit");

endmodule
